[hdl/ipc_pkg.sv]
package ipc_pkg;

  localparam int WORD_BITS = 16;
  localparam int PIXEL_BITS = 4;
  localparam int GROUP_BITS = WORD_BITS * PIXEL_BITS;
  localparam int COLUMN_BITS = 8;
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;
  localparam int DEFAULT_MAX_PLANES = 4;

  localparam logic [1:0] RES_FOUR_PLANES = 2'd0;
  localparam logic [1:0] RES_TWO_PLANES = 2'd1;
  localparam logic [1:0] RES_ONE_PLANE = 2'd2;

  localparam logic [1:0] REG_RESOLUTION = 2'd0;
  localparam logic [1:0] REG_MONO_BLACK_ON_WHITE = 2'd1;
  localparam logic [1:0] REG_GROUPS_PER_ROW = 2'd2;

  localparam logic [1:0] RESOLUTION_RESET = RES_FOUR_PLANES;
  localparam logic MONO_RESET = 1'b1;
  localparam logic [COLUMN_BITS-1:0] GROUPS_PER_ROW_RESET = 8'd20;

  typedef logic [PIXEL_BITS-1:0][WORD_BITS-1:0] planes_t;

  typedef struct packed {
    logic [1:0] resolution;
    logic mono_black_on_white;
    logic [COLUMN_BITS-1:0] groups_per_row;
  } cfg_t;

  typedef struct packed {
    planes_t planes;
    logic row_end;
  } stage_t;

endpackage

[hdl/ipc_if.sv]
interface ipc_word_if import ipc_pkg::*; ();
  logic valid;
  logic ready;
  logic [WORD_BITS-1:0] plane_word;

  modport source (output valid, output plane_word, input ready);
  modport sink (input valid, input plane_word, output ready);
endinterface

interface ipc_group_if import ipc_pkg::*; ();
  logic valid;
  logic ready;
  logic [GROUP_BITS-1:0] pixel_group;
  logic row_end;

  modport source (output valid, output pixel_group, output row_end, input ready);
  modport sink (input valid, input pixel_group, input row_end, output ready);
endinterface

[hdl/ipc_regs.sv]
module ipc_regs import ipc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  logic wr_en;
  logic [1:0] reg_index;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.resolution <= RESOLUTION_RESET;
      cfg.mono_black_on_white <= MONO_RESET;
      cfg.groups_per_row <= GROUPS_PER_ROW_RESET;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_RESOLUTION: cfg.resolution <= pwdata[1:0];
        REG_MONO_BLACK_ON_WHITE: cfg.mono_black_on_white <= pwdata[0];
        REG_GROUPS_PER_ROW: cfg.groups_per_row <= pwdata[COLUMN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_RESOLUTION: prdata = DATA_BITS'(cfg.resolution);
      REG_MONO_BLACK_ON_WHITE: prdata = DATA_BITS'(cfg.mono_black_on_white);
      REG_GROUPS_PER_ROW: prdata = DATA_BITS'(cfg.groups_per_row);
      default: prdata = '0;
    endcase
  end

endmodule

[hdl/ipc_collect.sv]
module ipc_collect import ipc_pkg::*; #(
  parameter int MAX_PLANES = DEFAULT_MAX_PLANES
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  ipc_word_if.sink   words,
  output logic       stage_valid,
  output stage_t     stage,
  input  logic       stage_ready
);

  localparam int HOLD_DEPTH = (MAX_PLANES > 1) ? MAX_PLANES - 1 : 1;
  localparam int HOLD_USED = (HOLD_DEPTH < PIXEL_BITS - 1) ? HOLD_DEPTH : PIXEL_BITS - 1;
  localparam int PLANE_LIMIT = (MAX_PLANES < PIXEL_BITS) ? MAX_PLANES : PIXEL_BITS;

  logic [WORD_BITS-1:0] held [HOLD_USED];
  logic [WORD_BITS-1:0] held_pad [PIXEL_BITS];
  logic [1:0] plane_position;
  logic [COLUMN_BITS-1:0] group_column;

  logic accept;
  logic [2:0] plane_count;
  logic [2:0] plane_count_raw;
  logic [1:0] last_plane;
  logic complete;
  planes_t planes;
  logic [COLUMN_BITS:0] column_inc;
  logic [COLUMN_BITS-1:0] row_len;
  logic row_end;

  assign words.ready = !stage_valid || stage_ready;
  assign accept = words.valid && words.ready && (plane_count != 3'd0);

  always_comb begin
    unique case (cfg.resolution)
      RES_FOUR_PLANES: plane_count_raw = 3'd4;
      RES_TWO_PLANES: plane_count_raw = 3'd2;
      RES_ONE_PLANE: plane_count_raw = 3'd1;
      default: plane_count_raw = 3'd0;
    endcase
    plane_count = (plane_count_raw > 3'(PLANE_LIMIT)) ? 3'(PLANE_LIMIT) : plane_count_raw;
  end

  assign last_plane = 2'(plane_count - 3'd1);
  assign complete = plane_position >= last_plane;

  for (genvar p = 0; p < PIXEL_BITS; p++) begin : g_pad
    if (p < HOLD_USED) begin : g_held
      assign held_pad[p] = held[p];
    end else begin : g_zero
      assign held_pad[p] = '0;
    end
  end

  always_comb begin
    for (int p = 0; p < PIXEL_BITS; p++) begin
      if (2'(p) == last_plane) begin
        planes[p] = words.plane_word;
      end else if (2'(p) < last_plane) begin
        planes[p] = held_pad[p];
      end else begin
        planes[p] = '0;
      end
    end
    if (plane_count == 3'd1 && !cfg.mono_black_on_white) begin
      planes[0] = ~words.plane_word;
    end
  end

  assign column_inc = {1'b0, group_column} + (COLUMN_BITS + 1)'(1);
  assign row_len = (cfg.groups_per_row == '0) ? COLUMN_BITS'(1) : cfg.groups_per_row;
  assign row_end = column_inc >= {1'b0, row_len};

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_position <= '0;
      group_column <= '0;
      stage_valid <= 1'b0;
      for (int i = 0; i < HOLD_USED; i++) begin
        held[i] <= '0;
      end
    end else begin
      if (accept && complete) begin
        stage_valid <= 1'b1;
        stage.planes <= planes;
        stage.row_end <= row_end;
        plane_position <= '0;
        group_column <= row_end ? '0 : column_inc[COLUMN_BITS-1:0];
      end else begin
        if (stage_ready) begin
          stage_valid <= 1'b0;
        end
        if (accept) begin
          plane_position <= plane_position + 2'd1;
          for (int i = 0; i < HOLD_USED; i++) begin
            if (plane_position == 2'(i)) begin
              held[i] <= words.plane_word;
            end
          end
        end
      end
    end
  end

endmodule

[hdl/ipc_transpose.sv]
module ipc_transpose import ipc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       stage_valid,
  input  stage_t     stage,
  output logic       stage_ready,
  ipc_group_if.source groups
);

  logic [GROUP_BITS-1:0] group_next;

  assign stage_ready = !groups.valid || groups.ready;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      for (int p = 0; p < PIXEL_BITS; p++) begin
        group_next[(WORD_BITS - 1 - b) * PIXEL_BITS + p] = stage.planes[p][WORD_BITS - 1 - b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      groups.valid <= 1'b0;
    end else if (stage_ready) begin
      groups.valid <= stage_valid;
      if (stage_valid) begin
        groups.pixel_group <= group_next;
        groups.row_end <= stage.row_end;
      end
    end
  end

endmodule

[hdl/interleaved_planar_to_chunky.sv]
// Channel   Modport  Payload                     Transaction
// words     sink     plane_word[15:0]            valid && ready
// groups    source   pixel_group[63:0], row_end  valid && ready
// apb       slave    paddr[3:0], pwdata[31:0]    psel && penable && pwrite
//
// One plane word is taken every cycle while words.ready is high; a finished group
// passes through the gather register and then the output register to groups.
// Reset (rst, synchronous) empties both registers, clears the plane position and
// row column, and loads the register defaults. A stall on groups holds the output;
// words.ready stays high while the gather register is empty or can move on.
module interleaved_planar_to_chunky import ipc_pkg::*; #(
  parameter int MAX_PLANES = DEFAULT_MAX_PLANES
) (
  input  logic                 clk,
  input  logic                 rst,
  ipc_word_if.sink             words,
  ipc_group_if.source          groups,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  cfg_t cfg;
  logic stage_valid;
  logic stage_ready;
  stage_t stage;

  ipc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ipc_collect #(
    .MAX_PLANES (MAX_PLANES)
  ) u_collect (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .words       (words),
    .stage_valid (stage_valid),
    .stage       (stage),
    .stage_ready (stage_ready)
  );

  ipc_transpose u_transpose (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage       (stage),
    .stage_ready (stage_ready),
    .groups      (groups)
  );

endmodule

[hdl/ipc_checker.sv]
module ipc_checker import ipc_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  words_valid,
  input logic                  words_ready,
  input logic                  groups_valid,
  input logic                  groups_ready,
  input logic [GROUP_BITS-1:0] pixel_group,
  input logic                  row_end,
  input logic                  pready
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !groups_valid)
    else $error("groups.valid high after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    groups_valid && !groups_ready |=> groups_valid && $stable(pixel_group) && $stable(row_end))
    else $error("stalled group changed");

  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    groups_ready |-> words_ready)
    else $error("input stalled while output drains");

  a_group_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(groups_valid) |-> $past(words_valid && words_ready, 2) && pready)
    else $error("group appeared without a word two cycles before");

endmodule

bind interleaved_planar_to_chunky ipc_checker u_ipc_checker (
  .clk          (clk),
  .rst          (rst),
  .words_valid  (words.valid),
  .words_ready  (words.ready),
  .groups_valid (groups.valid),
  .groups_ready (groups.ready),
  .pixel_group  (groups.pixel_group),
  .row_end      (groups.row_end),
  .pready       (pready)
);
